// ===== rtl/core/epwr_pkg.sv =====
// Shared types, register indexes and constants of the echo pulse width ranger.
package epwr_pkg;

  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 20;
  localparam int unsigned CaptureW  = 16;
  localparam int unsigned PeriodW   = 16;
  localparam int unsigned OvfW      = 8;
  localparam int unsigned WidthW    = 20;
  localparam int unsigned ScaleW    = 16;
  localparam int unsigned OffsetW   = 17;
  localparam int unsigned DistW     = 23;
  localparam int unsigned ScaleShift = 8;

  // Register indexes on the configuration channel
  localparam logic [CfgIdxW-1:0] REG_TIMER_PERIOD    = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_MIN_WIDTH       = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_MAX_WIDTH       = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_DISTANCE_SCALE  = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_DISTANCE_OFFSET = 3'd4;

  // Reset values of the registers
  localparam logic [PeriodW-1:0]        RstTimerPeriod    = 16'd4000;
  localparam logic [CaptureW-1:0]       RstMinWidth       = 16'd10;
  localparam logic [WidthW-1:0]         RstMaxWidth       = 20'd4000;
  localparam logic [ScaleW-1:0]         RstDistanceScale  = 16'd40757;
  localparam logic signed [OffsetW-1:0] RstDistanceOffset = -17'sd6086;

  // Event kinds carried on the input tuser
  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_EDGE = 1'b1;

  typedef struct packed {
    logic [PeriodW-1:0]        timer_period;
    logic [CaptureW-1:0]       min_width;
    logic [WidthW-1:0]         max_width;
    logic [ScaleW-1:0]         distance_scale;
    logic signed [OffsetW-1:0] distance_offset;
  } epwr_cfg_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_MUL,
    BK_SUM,
    BK_OUT
  } epwr_back_state_e;

endpackage

// ===== rtl/core/epwr_cfg.sv =====
// Configuration register file of the echo pulse width ranger.
module epwr_cfg
  import epwr_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                wr_en_i,
  input  logic [CfgIdxW-1:0]  wr_index_i,
  input  logic [CfgDataW-1:0] wr_data_i,
  output epwr_cfg_t           cfg_o
);

  epwr_cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      unique case (wr_index_i)
        REG_TIMER_PERIOD:    cfg_d.timer_period    = wr_data_i[PeriodW-1:0];
        REG_MIN_WIDTH:       cfg_d.min_width       = wr_data_i[CaptureW-1:0];
        REG_MAX_WIDTH:       cfg_d.max_width       = wr_data_i[WidthW-1:0];
        REG_DISTANCE_SCALE:  cfg_d.distance_scale  = wr_data_i[ScaleW-1:0];
        REG_DISTANCE_OFFSET: cfg_d.distance_offset = signed'(wr_data_i[OffsetW-1:0]);
        default:             cfg_d = cfg_q;  // unknown index: drop the write
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.timer_period    <= RstTimerPeriod;
      cfg_q.min_width       <= RstMinWidth;
      cfg_q.max_width       <= RstMaxWidth;
      cfg_q.distance_scale  <= RstDistanceScale;
      cfg_q.distance_offset <= RstDistanceOffset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/core/epwr_front.sv =====
// Front end: takes timer events, tracks the edge phase and forms pulse widths.
module epwr_front
  import epwr_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  epwr_cfg_t           cfg_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                command_i,
  input  logic [CaptureW-1:0] capture_value_i,
  input  logic                q_full_i,
  output logic                push_o,
  output logic [WidthW-1:0]   push_width_o
);

  localparam int unsigned SumW = OvfW + PeriodW + 2;

  logic [OvfW-1:0]     ovf_q, ovf_d;
  logic [CaptureW-1:0] start_q, start_d;
  logic                phase_q, phase_d;

  logic                       accept;
  logic [OvfW+PeriodW-1:0]    ovf_ticks;
  logic signed [SumW-1:0]     width_s;
  logic                       in_range;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;

  // width = capture - start + overflows * period, kept signed
  assign ovf_ticks = ovf_q * cfg_i.timer_period;
  assign width_s   = signed'(SumW'(capture_value_i)) - signed'(SumW'(start_q))
                   + signed'(SumW'(ovf_ticks));
  assign in_range  = (width_s > signed'(SumW'(cfg_i.min_width)))
                  && (width_s < signed'(SumW'(cfg_i.max_width)));

  always_comb begin
    ovf_d   = ovf_q;
    start_d = start_q;
    phase_d = phase_q;
    push_o  = 1'b0;
    if (accept) begin
      case (command_i)
        CMD_TICK: ovf_d = ovf_q + OvfW'(1);
        default: begin
          ovf_d   = '0;
          phase_d = !phase_q;
          if (!phase_q) begin
            start_d = capture_value_i;
          end else begin
            push_o = in_range;
          end
        end
      endcase
    end
  end

  assign push_width_o = width_s[WidthW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovf_q   <= '0;
      start_q <= '0;
      phase_q <= 1'b0;
    end else begin
      ovf_q   <= ovf_d;
      start_q <= start_d;
      phase_q <= phase_d;
    end
  end

endmodule

// ===== rtl/core/epwr_fifo.sv =====
// Short queue of accepted pulse widths between front and back end.
module epwr_fifo
  import epwr_pkg::*;
#(
  parameter int unsigned Depth = 2
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic [WidthW-1:0] push_data_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic [WidthW-1:0] pop_data_o,
  output logic              empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [WidthW-1:0] mem_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]   cnt_q;

  function automatic logic [PtrW-1:0] ptr_next(input logic [PtrW-1:0] p);
    ptr_next = (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  assign full_o     = (cnt_q == CntW'(Depth));
  assign empty_o    = (cnt_q == '0);
  assign pop_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) wr_ptr_q <= ptr_next(wr_ptr_q);
      if (pop_i)  rd_ptr_q <= ptr_next(rd_ptr_q);
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i) else $error("push into full queue");
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_o |-> !pop_i) else $error("pop from empty queue");

endmodule

// ===== rtl/core/epwr_back.sv =====
// Back end: scales an accepted width to a distance and holds the result.
module epwr_back
  import epwr_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  epwr_cfg_t         cfg_i,
  input  logic              q_empty_i,
  input  logic [WidthW-1:0] q_data_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [WidthW-1:0] pulse_width_o,
  output logic [DistW-1:0]  distance_o
);

  localparam int unsigned ProdW = WidthW + ScaleW;
  localparam int unsigned ShW   = ProdW - ScaleShift;
  localparam int unsigned SumW  = ShW + 2;
  localparam logic signed [SumW-1:0] SumMax = SumW'(signed'(2 ** (DistW - 1) - 1));
  localparam logic signed [SumW-1:0] SumMin = -SumW'(signed'(2 ** (DistW - 1)));

  epwr_back_state_e state_q, state_d;

  logic [WidthW-1:0] width_q;
  logic [ProdW-1:0]  prod_q;
  logic [DistW-1:0]  dist_q;
  logic signed [SumW-1:0] sum;
  logic [DistW-1:0]  dist_sat;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_IDLE: if (!q_empty_i) state_d = BK_MUL;
      BK_MUL:  state_d = BK_SUM;
      BK_SUM:  state_d = BK_OUT;
      BK_OUT:  if (out_ready_i) state_d = BK_IDLE;
      default: state_d = BK_IDLE;
    endcase
  end

  always_comb begin
    pop_o       = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      BK_IDLE: pop_o = !q_empty_i;
      BK_OUT:  out_valid_o = 1'b1;
      default: ;
    endcase
  end

  // Drop the low fraction bits of the product, add the offset, saturate
  assign sum = signed'(SumW'(prod_q[ProdW-1:ScaleShift]))
             + SumW'(cfg_i.distance_offset);
  always_comb begin
    if (sum > SumMax) begin
      dist_sat = SumMax[DistW-1:0];
    end else if (sum < SumMin) begin
      dist_sat = SumMin[DistW-1:0];
    end else begin
      dist_sat = sum[DistW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) width_q <= q_data_i;
    if (state_q == BK_MUL) prod_q <= width_q * cfg_i.distance_scale;
    if (state_q == BK_SUM) dist_q <= dist_sat;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign pulse_width_o = width_q;
  assign distance_o    = dist_q;

  a_pop_starts_mul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> state_q == BK_MUL) else $error("pop did not start a multiply");
  a_valid_after_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q) == BK_SUM)
    else $error("result shown without a finished sum");

endmodule

// ===== rtl/core/echo_pulse_width_ranger_unit.sv =====
// Top level of the echo pulse width ranger: timer events in, widths and distances out.
//
// Timer events arrive on the slave stream: tuser carries the kind (overflow tick
// or edge capture) and tdata the captured counter value. An 8-bit wrapping count
// of overflow ticks runs between edges; the first edge of a pair stores the start
// value, the second forms width = capture - start + overflows * timer_period and
// returns to the first phase. Widths strictly between min_width and max_width go
// into a short queue (FifoDepth entries); other edges and ticks produce nothing.
// The back end takes one queued width at a time: a 20x16 multiply by
// distance_scale (Q8.8) into a product register, then shift right by 8, add
// distance_offset (Q17.0 signed) and saturate to 23 signed bits into an output
// register that holds the result until the master side takes it. An event is
// accepted whenever the queue has room; the back end pops the next width only
// after the master side has taken the current result. The multiply is the widest
// path. Registers are written over the configuration channel, which is always
// ready; write it only while no event is in flight. Unknown register indexes are
// ignored.
module echo_pulse_width_ranger_unit
  import epwr_pkg::*;
#(
  parameter int unsigned FifoDepth = 2  // queue entries, 2 or more
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // Configuration write channel
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  // Event stream
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [15:0]         s_axis_tdata,   // [15:0] capture_value
  input  logic [0:0]          s_axis_tuser,   // [0] command
  // Result stream
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [47:0]         m_axis_tdata    // [19:0] pulse_width, [42:20] distance, zero fill
);

  epwr_cfg_t         cfg;
  logic              q_full, q_empty, push, pop;
  logic [WidthW-1:0] push_width, pop_width, pulse_width;
  logic [DistW-1:0]  distance;

  // Registers accept a transfer every cycle
  assign cfg_ready_o = 1'b1;

  epwr_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_valid_i && cfg_ready_o),
    .wr_index_i (cfg_index_i),
    .wr_data_i  (cfg_data_i),
    .cfg_o      (cfg)
  );

  // Front end: advance the edge phase and forward in-range widths
  epwr_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg),
    .in_valid_i      (s_axis_tvalid),
    .in_ready_o      (s_axis_tready),
    .command_i       (s_axis_tuser[0]),
    .capture_value_i (s_axis_tdata[CaptureW-1:0]),
    .q_full_i        (q_full),
    .push_o          (push),
    .push_width_o    (push_width)
  );

  epwr_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_width),
    .full_o      (q_full),
    .pop_i       (pop),
    .pop_data_o  (pop_width),
    .empty_o     (q_empty)
  );

  // Back end: scale to distance and hold until transfer
  epwr_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .q_empty_i     (q_empty),
    .q_data_i      (pop_width),
    .pop_o         (pop),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .pulse_width_o (pulse_width),
    .distance_o    (distance)
  );

  assign m_axis_tdata = {{(48 - WidthW - DistW){1'b0}}, distance, pulse_width};

endmodule
